/* design/tlik_pkg.sv */
package tlik_pkg;

  localparam int POS_W = 16;
  localparam int ANG_W = 16;
  localparam int CFG_W = 15;

  localparam int CIN_W = 49;
  localparam int CX_W  = 44;
  localparam int CZ_W  = 33;

  localparam int CORDIC_STEPS = 31;
  localparam int NORM_N       = 11;
  localparam int CORDIC_LAT   = NORM_N + 1 + CORDIC_STEPS;

  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;
  localparam int SQ_LAT   = SQ_OUT_W;

  localparam int REACH_MARGIN = 10;

  localparam logic signed [CZ_W-1:0] QUARTER_TURN = CZ_W'(1 << 30);
  localparam logic signed [CZ_W-1:0] HALF_TURN    = QUARTER_TURN <<< 1;

  typedef enum logic [0:0] {
    REG_UPPER_LEG = 1'b0,
    REG_LOWER_LEG = 1'b1
  } cfg_reg_e;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

endpackage

/* design/tlik_isqrt.sv */
module tlik_isqrt import tlik_pkg::*; (
  input  logic                clk_i,
  input  logic [SQ_IN_W-1:0]  rad_i,
  output logic [SQ_OUT_W-1:0] root_o
);

  logic [SQ_IN_W-1:0] v_q   [SQ_LAT-1];
  logic [SQ_IN_W-1:0] res_q [SQ_LAT];

  for (genvar i = 0; i < SQ_LAT; i++) begin : g_step
    localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * i);
    logic [SQ_IN_W-1:0] v_in;
    logic [SQ_IN_W-1:0] res_in;
    logic [SQ_IN_W-1:0] trial;
    logic               take;

    if (i == 0) begin : g_first
      assign v_in   = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign res_in = res_q[i-1];
    end

    assign trial = res_in + BIT;
    assign take  = v_in >= trial;

    always_ff @(posedge clk_i) begin
      res_q[i] <= take ? (res_in >> 1) + BIT : res_in >> 1;
    end

    if (i < SQ_LAT - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        v_q[i] <= take ? v_in - trial : v_in;
      end
    end
  end

  assign root_o = res_q[SQ_LAT-1][SQ_OUT_W-1:0];

endmodule

/* design/tlik_cordic.sv */
module tlik_cordic import tlik_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [CIN_W-1:0] y_i,
  input  logic signed [CIN_W-1:0] x_i,
  output logic signed [CZ_W-1:0]  angle_o
);

  logic                    zf_q [CORDIC_LAT-1];
  logic signed [CIN_W-1:0] nx_q [NORM_N];
  logic signed [CIN_W-1:0] ny_q [NORM_N];
  logic        [CIN_W-1:0] nm_q [NORM_N-1];
  logic signed [CX_W-1:0]  px_q;
  logic signed [CX_W-1:0]  py_q;
  logic signed [CZ_W-1:0]  pz_q;
  logic signed [CX_W-1:0]  ix_q [CORDIC_STEPS-1];
  logic signed [CX_W-1:0]  iy_q [CORDIC_STEPS-1];
  logic signed [CZ_W-1:0]  iz_q [CORDIC_STEPS-1];
  logic signed [CZ_W-1:0]  angle_q;

  logic [CIN_W-1:0] mx;
  logic [CIN_W-1:0] my;

  assign mx = x_i[CIN_W-1] ? CIN_W'(-x_i) : CIN_W'(x_i);
  assign my = y_i[CIN_W-1] ? CIN_W'(-y_i) : CIN_W'(y_i);

  always_ff @(posedge clk_i) begin
    zf_q[0] <= (x_i == '0) && (y_i == '0);
    for (int k = 1; k < CORDIC_LAT - 1; k++) zf_q[k] <= zf_q[k-1];
    nx_q[0] <= x_i;
    ny_q[0] <= y_i;
    nm_q[0] <= (mx > my) ? mx : my;
  end

  // scale the larger magnitude into [2^40, 2^41)
  for (genvar j = 1; j < NORM_N; j++) begin : g_norm
    localparam int K = (j <= 4) ? (16 >> j) : (64 >> (j - 4));
    logic sh;

    if (j <= 4) begin : g_rsh
      assign sh = (nm_q[j-1] >> (40 + K)) != '0;
      always_ff @(posedge clk_i) begin
        nx_q[j] <= sh ? nx_q[j-1] >>> K : nx_q[j-1];
        ny_q[j] <= sh ? ny_q[j-1] >>> K : ny_q[j-1];
      end
      if (j < NORM_N - 1) begin : g_m
        always_ff @(posedge clk_i) begin
          nm_q[j] <= sh ? nm_q[j-1] >> K : nm_q[j-1];
        end
      end
    end else begin : g_lsh
      assign sh = (nm_q[j-1] >> (41 - K)) == '0;
      always_ff @(posedge clk_i) begin
        nx_q[j] <= sh ? nx_q[j-1] <<< K : nx_q[j-1];
        ny_q[j] <= sh ? ny_q[j-1] <<< K : ny_q[j-1];
      end
      if (j < NORM_N - 1) begin : g_m
        always_ff @(posedge clk_i) begin
          nm_q[j] <= sh ? nm_q[j-1] << K : nm_q[j-1];
        end
      end
    end
  end

  logic signed [CX_W-1:0] xn;
  logic signed [CX_W-1:0] yn;

  assign xn = CX_W'(nx_q[NORM_N-1]);
  assign yn = CX_W'(ny_q[NORM_N-1]);

  // left half plane: rotate by a quarter turn first
  always_ff @(posedge clk_i) begin
    if (xn < 0) begin
      if (yn >= 0) begin
        px_q <= yn;
        py_q <= -xn;
        pz_q <= QUARTER_TURN;
      end else begin
        px_q <= -yn;
        py_q <= xn;
        pz_q <= -QUARTER_TURN;
      end
    end else begin
      px_q <= xn;
      py_q <= yn;
      pz_q <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CX_W-1:0] xc;
    logic signed [CX_W-1:0] yc;
    logic signed [CZ_W-1:0] zc;
    logic signed [CZ_W-1:0] za;

    if (i == 0) begin : g_first
      assign xc = px_q;
      assign yc = py_q;
      assign zc = pz_q;
    end else begin : g_next
      assign xc = ix_q[i-1];
      assign yc = iy_q[i-1];
      assign zc = iz_q[i-1];
    end

    assign za = CZ_W'(ATAN_TAB[i]);

    if (i < CORDIC_STEPS - 1) begin : g_mid
      logic signed [CX_W-1:0] xs;
      logic signed [CX_W-1:0] ys;

      assign xs = xc >>> i;
      assign ys = yc >>> i;

      always_ff @(posedge clk_i) begin
        if (!yc[CX_W-1]) begin
          ix_q[i] <= xc + ys;
          iy_q[i] <= yc - xs;
          iz_q[i] <= zc + za;
        end else begin
          ix_q[i] <= xc - ys;
          iy_q[i] <= yc + xs;
          iz_q[i] <= zc - za;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (zf_q[CORDIC_LAT-2]) begin
          angle_q <= '0;
        end else begin
          angle_q <= yc[CX_W-1] ? zc - za : zc + za;
        end
      end
    end
  end

  assign angle_o = angle_q;

endmodule

/* design/two_link_leg_inverse_kinematics.sv */
// each accepted start yields a done strobe together with its result
// throughput: one transaction per cycle, busy_o stays low
// the depth is set by a 32-step square root followed by a 43-step atan2 unit
// the receiver cannot stall, so nothing waits inside the pipeline
// reset clears the valid line and sets both leg lengths to 1000
module two_link_leg_inverse_kinematics import tlik_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [POS_W-1:0] foot_x_i,
  input  logic signed [POS_W-1:0] foot_y_i,
  input  logic signed [POS_W-1:0] foot_z_i,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  output logic                    done_o,
  output logic signed [ANG_W-1:0] hip_yaw_angle_o,
  output logic signed [ANG_W-1:0] hip_pitch_angle_o,
  output logic signed [ANG_W-1:0] knee_angle_o
);

  localparam int LAT       = 9 + SQ_LAT + CORDIC_LAT;
  localparam int YAW_DLY   = 5;
  localparam int ALPHA_DLY = 7 + SQ_LAT;
  localparam logic signed [ANG_W-1:0] YAW_LIM = ANG_W'(1) <<< (ANG_W - 2);

  function automatic logic [ANG_W-1:0] angle_round(input logic signed [CZ_W-1:0] a);
    logic [CZ_W-1:0] t;
    t = CZ_W'(a) + (CZ_W'(1) << (31 - ANG_W));
    return t[31 -: ANG_W];
  endfunction

  // leg lengths and derived constants
  logic [CFG_W-1:0] l1_q, l2_q;
  logic [15:0]      lo_q, hi_q;
  logic [29:0]      l1sq_q, l2sq_q, l1l2_q;
  logic [31:0]      lo2_q, hi2_q;
  logic [30:0]      sumsq_q, den_q;
  logic [45:0]      l1den_q;
  logic [61:0]      den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= CFG_W'(1000);
      l2_q <= CFG_W'(1000);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_UPPER_LEG: l1_q <= cfg_wdata_i;
        REG_LOWER_LEG: l2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [15:0] lsum;
  assign lsum = {1'b0, l1_q} + {1'b0, l2_q};

  always_ff @(posedge clk_i) begin
    lo_q    <= ((l1_q > l2_q) ? {1'b0, l1_q - l2_q} : {1'b0, l2_q - l1_q}) + 16'(REACH_MARGIN);
    hi_q    <= (lsum > 16'(REACH_MARGIN)) ? lsum - 16'(REACH_MARGIN) : '0;
    l1sq_q  <= 30'(l1_q) * 30'(l1_q);
    l2sq_q  <= 30'(l2_q) * 30'(l2_q);
    l1l2_q  <= 30'(l1_q) * 30'(l2_q);
    lo2_q   <= 32'(lo_q) * 32'(lo_q);
    hi2_q   <= 32'(hi_q) * 32'(hi_q);
    sumsq_q <= {1'b0, l1sq_q} + {1'b0, l2sq_q};
    den_q   <= {l1l2_q, 1'b0};
    l1den_q <= 46'(l1_q) * 46'(den_q);
    den2_q  <= 62'(den_q) * 62'(den_q);
  end

  // valid line
  logic v_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= start_i;
      for (int i = 1; i < LAT; i++) v_q[i] <= v_q[i-1];
    end
  end

  assign busy_o = 1'b0;
  assign done_o = v_q[LAT-1];

  // front: squares, reach, scaling
  logic signed [POS_W-1:0]   x1_q, y1_q, z1_q, y2_q;
  logic        [30:0]        xx1_q, zz1_q;
  logic        [31:0]        r2_2_q, r2c3_q;
  logic        [63:0]        rady3_q;
  logic signed [32:0]        ys3_q;
  logic signed [2*POS_W-1:0] xsq, zsq;
  logic        [31:0]        r2lo;

  assign xsq  = (2*POS_W)'(foot_x_i) * (2*POS_W)'(foot_x_i);
  assign zsq  = (2*POS_W)'(foot_z_i) * (2*POS_W)'(foot_z_i);
  assign r2lo = (r2_2_q < lo2_q) ? lo2_q : r2_2_q;

  always_ff @(posedge clk_i) begin
    x1_q    <= foot_x_i;
    y1_q    <= foot_y_i;
    z1_q    <= foot_z_i;
    xx1_q   <= xsq[30:0];
    zz1_q   <= zsq[30:0];
    r2_2_q  <= {1'b0, xx1_q} + {1'b0, zz1_q};
    y2_q    <= y1_q;
    rady3_q <= r2_2_q[31] ? {2'b00, r2_2_q, 30'b0} : {r2_2_q, 32'b0};
    ys3_q   <= r2_2_q[31] ? {{2{y2_q[15]}}, y2_q, 15'b0} : {y2_q[15], y2_q, 16'b0};
    r2c3_q  <= (r2lo > hi2_q) ? hi2_q : r2lo;
  end

  // yaw branch
  logic        [SQ_OUT_W-1:0] sq_yaw;
  logic signed [32:0]         ysd_q [SQ_LAT];
  logic signed [CZ_W-1:0]     yaw_ang;
  logic signed [CZ_W-1:0]     yawd_q [YAW_DLY];

  tlik_isqrt u_isqrt_yaw (
    .clk_i  (clk_i),
    .rad_i  (rady3_q),
    .root_o (sq_yaw)
  );

  always_ff @(posedge clk_i) begin
    ysd_q[0] <= ys3_q;
    for (int i = 1; i < SQ_LAT; i++) ysd_q[i] <= ysd_q[i-1];
  end

  tlik_cordic u_cordic_yaw (
    .clk_i   (clk_i),
    .y_i     (CIN_W'(ysd_q[SQ_LAT-1])),
    .x_i     (CIN_W'(signed'({1'b0, sq_yaw}))),
    .angle_o (yaw_ang)
  );

  always_ff @(posedge clk_i) begin
    yawd_q[0] <= yaw_ang;
    for (int i = 1; i < YAW_DLY; i++) yawd_q[i] <= yawd_q[i-1];
  end

  // foot direction branch
  logic signed [CZ_W-1:0] alpha_ang;
  logic signed [CZ_W-1:0] alphad_q [ALPHA_DLY];

  tlik_cordic u_cordic_alpha (
    .clk_i   (clk_i),
    .y_i     (CIN_W'(x1_q)),
    .x_i     (-CIN_W'(z1_q)),
    .angle_o (alpha_ang)
  );

  always_ff @(posedge clk_i) begin
    alphad_q[0] <= alpha_ang;
    for (int i = 1; i < ALPHA_DLY; i++) alphad_q[i] <= alphad_q[i-1];
  end

  // law of cosines branch
  logic signed [33:0]         diff4, dpos;
  logic signed [31:0]         num4_q, num5_q, num6_q;
  logic        [30:0]         anum;
  logic        [61:0]         nsq5_q, rad6_q;
  logic        [SQ_OUT_W-1:0] sq_knee;
  logic signed [31:0]         numd_q [SQ_LAT];
  logic        [46:0]         p7_q, p8_q;
  logic signed [47:0]         q7_q;
  logic        [SQ_OUT_W-1:0] sn7_q, sn8_q;
  logic signed [31:0]         num7_q, num8_q;
  logic signed [CIN_W-1:0]    bx8_q;

  assign diff4 = $signed({3'b0, sumsq_q}) - $signed({2'b0, r2c3_q});
  assign dpos  = $signed({3'b0, den_q});
  assign anum  = num4_q[31] ? 31'(-num4_q) : num4_q[30:0];

  always_ff @(posedge clk_i) begin
    if (diff4 > dpos) begin
      num4_q <= 32'(dpos);
    end else if (diff4 < -dpos) begin
      num4_q <= 32'(-dpos);
    end else begin
      num4_q <= 32'(diff4);
    end
    nsq5_q <= 62'(anum) * 62'(anum);
    num5_q <= num4_q;
    rad6_q <= den2_q - nsq5_q;
    num6_q <= num5_q;
  end

  tlik_isqrt u_isqrt_knee (
    .clk_i  (clk_i),
    .rad_i  ({2'b00, rad6_q}),
    .root_o (sq_knee)
  );

  always_ff @(posedge clk_i) begin
    numd_q[0] <= num6_q;
    for (int i = 1; i < SQ_LAT; i++) numd_q[i] <= numd_q[i-1];
    p7_q   <= 47'(l2_q) * 47'(sq_knee);
    q7_q   <= 48'($signed({1'b0, l2_q})) * 48'(numd_q[SQ_LAT-1]);
    sn7_q  <= sq_knee;
    num7_q <= numd_q[SQ_LAT-1];
    p8_q   <= p7_q;
    bx8_q  <= $signed({3'b0, l1den_q}) - CIN_W'(q7_q);
    sn8_q  <= sn7_q;
    num8_q <= num7_q;
  end

  logic signed [CZ_W-1:0] acos_ang, beta_ang, acos_c;

  tlik_cordic u_cordic_acos (
    .clk_i   (clk_i),
    .y_i     (CIN_W'(signed'({1'b0, sn8_q}))),
    .x_i     (CIN_W'(num8_q)),
    .angle_o (acos_ang)
  );

  tlik_cordic u_cordic_beta (
    .clk_i   (clk_i),
    .y_i     (CIN_W'(signed'({2'b00, p8_q}))),
    .x_i     (bx8_q),
    .angle_o (beta_ang)
  );

  assign acos_c = (acos_ang < 0) ? '0 : ((acos_ang > HALF_TURN) ? HALF_TURN : acos_ang);

  // output stage
  always_ff @(posedge clk_i) begin
    hip_yaw_angle_o   <= angle_round(yawd_q[YAW_DLY-1]);
    hip_pitch_angle_o <= angle_round(alphad_q[ALPHA_DLY-1] - beta_ang);
    knee_angle_o      <= angle_round(acos_c) - (ANG_W'(1) << (ANG_W - 1));
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("transaction lost in pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (knee_angle_o[ANG_W-1] || knee_angle_o == '0))
    else $error("knee angle positive");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hip_yaw_angle_o >= -YAW_LIM && hip_yaw_angle_o <= YAW_LIM))
    else $error("hip yaw out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5+SQ_LAT] |-> (sq_knee <= {1'b0, den_q}))
    else $error("knee sine exceeds denominator");

endmodule
